// ----- rtl/sbcg_pkg.sv -----
// Shared types and constants for the spectral bin compander gain unit.
package sbcg_pkg;

  localparam logic [16:0] UNITY_GAIN = 17'd65536;

  // Configuration register indexes
  localparam logic [2:0] REG_EXPAND_MODE     = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_POWER = 3'd1;
  localparam logic [2:0] REG_ATTACK_FACTOR   = 3'd2;
  localparam logic [2:0] REG_RELEASE_FACTOR  = 3'd3;
  localparam logic [2:0] REG_INVERT_OUTPUT   = 3'd4;

  // Item kinds
  localparam logic KIND_BIN  = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  // Sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CLEAR  = 3'd1;
  localparam logic [2:0] ST_PWR    = 3'd2;
  localparam logic [2:0] ST_TWEAK  = 3'd3;
  localparam logic [2:0] ST_SEARCH = 3'd4;
  localparam logic [2:0] ST_GAIN   = 3'd5;
  localparam logic [2:0] ST_SCALE  = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  // Largest power step table the packed table type can carry
  localparam int MAX_STEPS = 128;

  typedef logic [47:0] power_t;
  typedef logic [48*MAX_STEPS-1:0] power_table_t;

  // Power step table of n entries, entry i = round(2^46 * 10^((i - n)/10)),
  // packed 48 bits per entry with entry 0 in the low bits
  function automatic power_table_t power_table(input int n);
    logic [63:0] mant [10];
    logic [63:0] p;
    logic [63:0] num;
    logic [63:0] quo;
    logic [63:0] rem;
    int d;
    int q;
    int r;
    power_table_t t;
    mant[0] = 64'd70368744177664; mant[1] = 64'd55895880342408;
    mant[2] = 64'd44399675960742; mant[3] = 64'd35267916228741;
    mant[4] = 64'd28014301640811; mant[5] = 64'd22252550769300;
    mant[6] = 64'd17675829370400; mant[7] = 64'd14040410340800;
    mant[8] = 64'd11152694360700; mant[9] = 64'd8858900023600;
    t = '0;
    for (int i = 0; i < MAX_STEPS; i++) begin
      if (i < n) begin
        // split the distance into decades and a mantissa position
        d = n - i;
        q = 0;
        r = d;
        for (int k = 0; k < 13; k++) begin
          if (r >= 10) begin
            r = r - 10;
            q = q + 1;
          end
        end
        p = 64'd1;
        for (int k = 0; k < 13; k++) begin
          if (k < q) p = p * 64'd10;
        end
        // rounded quotient by restoring long division
        num = mant[r] + (p >> 1);
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
          rem = {rem[62:0], num[b]};
          if (rem >= p) begin
            rem = rem - p;
            quo[b] = 1'b1;
          end
        end
        t[48*i +: 48] = quo[47:0];
      end
    end
    power_table = t;
  endfunction

endpackage

// ----- rtl/spectral_bin_compander_gain_unit.sv -----
// Top level of the spectral bin compander gain unit.
//
// Works on one request at a time. After reset a clearing pass sets every bin
// gain to unity and every gain step to unity, during which no request is
// taken (configuration writes still are). A load request is written to the
// step table as it is accepted, and the next request may follow in the next
// cycle. A bin request puts its result in the output register as the
// sequencer returns to idle, both in the same cycle, so the next request can
// then be taken. The time is set by the search that walks the power step table
// one entry a cycle and by the 24x24 and 32x26 products split over several
// registered steps; the result then waits in the output register until
// taken, while the next request may already be accepted.
// A finished result also waits in the sequencer while the output register
// still holds an untaken one.
module spectral_bin_compander_gain_unit #(
  parameter int HALF_BINS   = 512,
  parameter int LEVEL_STEPS = 96
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [9:0]  bin_index,
  input  logic signed [23:0] bin_real,
  input  logic signed [23:0] bin_imag,
  input  logic [19:0] level_weight,
  input  logic [25:0] tilt_weight,
  input  logic [16:0] step_gain,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_index,
  output logic signed [23:0] out_real,
  output logic signed [23:0] out_imag,
  output logic [16:0] bin_gain
);

  localparam int GW  = $clog2(HALF_BINS + 1);
  localparam int SW  = $clog2(LEVEL_STEPS);
  localparam int CLR = (HALF_BINS + 1 > LEVEL_STEPS) ? HALF_BINS + 1 : LEVEL_STEPS;
  localparam int CW  = $clog2(CLR + 1);
  localparam sbcg_pkg::power_table_t STEP_TABLE = sbcg_pkg::power_table(LEVEL_STEPS);

  // Configuration registers
  logic        expand_mode;
  logic [47:0] threshold_power;
  logic [25:0] attack_factor;
  logic [15:0] release_factor;
  logic        invert_output;

  always_ff @(posedge clk) begin
    if (rst) begin
      expand_mode     <= 1'b0;
      threshold_power <= 48'd70368744177;
      attack_factor   <= 26'd74920;
      release_factor  <= 16'd63806;
      invert_output   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        sbcg_pkg::REG_EXPAND_MODE:     expand_mode     <= cfg_data[0];
        sbcg_pkg::REG_THRESHOLD_POWER: threshold_power <= cfg_data;
        sbcg_pkg::REG_ATTACK_FACTOR:   attack_factor   <= cfg_data[25:0];
        sbcg_pkg::REG_RELEASE_FACTOR:  release_factor  <= cfg_data[15:0];
        sbcg_pkg::REG_INVERT_OUTPUT:   invert_output   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Power step constants
  sbcg_pkg::power_t step_rom [LEVEL_STEPS];
  always_comb begin
    for (int i = 0; i < LEVEL_STEPS; i++) step_rom[i] = STEP_TABLE[48*i +: 48];
  end

  // Memories
  logic [16:0] gain_mem [HALF_BINS + 1];
  logic [16:0] step_mem [LEVEL_STEPS];
  logic [16:0] gain_rd, step_rd;

  logic [2:0]  state;
  logic [CW-1:0] clr_cnt;
  logic [1:0]  phase;
  logic [GW-1:0] idx;
  logic signed [23:0] re, im;
  logic [19:0] lw;
  logic [25:0] tw;
  logic [47:0] pw;
  logic [50:0] tp;
  logic [60:0] wp, acc;
  logic [SW-1:0] sidx;
  logic        found;
  logic [16:0] floor_gain, g_new;
  logic signed [41:0] pr, pi;

  logic [GW-1:0] gain_waddr;
  logic [16:0]   gain_wdata;
  logic          gain_we;
  logic [SW-1:0] step_waddr;
  logic [16:0]   step_wdata;
  logic          step_we;
  logic [SW-1:0] step_raddr;

  logic accept, ld_ok, bin_ok;
  logic [16:0] sg_sat;
  assign in_stall = (state != sbcg_pkg::ST_IDLE) || (out_valid && phase != 2'd0);
  assign accept   = in_valid && !in_stall;
  assign sg_sat   = (step_gain > sbcg_pkg::UNITY_GAIN) ? sbcg_pkg::UNITY_GAIN : step_gain;
  assign ld_ok    = {22'd0, bin_index} < 32'(LEVEL_STEPS);
  assign bin_ok   = {22'd0, bin_index} <= 32'(HALF_BINS);

  // Memory write and read ports
  always_ff @(posedge clk) begin
    if (gain_we) gain_mem[gain_waddr] <= gain_wdata;
    gain_rd <= gain_mem[idx];
  end
  always_ff @(posedge clk) begin
    if (step_we) step_mem[step_waddr] <= step_wdata;
    step_rd <= step_mem[step_raddr];
  end

  // Compute gain updates
  logic reduce;
  logic [42:0] rel_p;
  logic [42:0] att_p;
  logic [16:0] rel_g, att_g;
  assign reduce = expand_mode ? (wp < {13'd0, threshold_power})
                              : (wp > {13'd0, threshold_power});
  assign rel_p  = 43'(gain_rd) * 43'(release_factor);
  assign att_p  = 43'(gain_rd) * 43'(attack_factor);
  assign rel_g  = (rel_p[32:16] < floor_gain) ? floor_gain : rel_p[32:16];
  assign att_g  = (att_p[42:16] > 27'(sbcg_pkg::UNITY_GAIN)) ? sbcg_pkg::UNITY_GAIN
                                                            : att_p[32:16];

  // Write port selection
  always_comb begin
    gain_we    = 1'b0;
    gain_waddr = idx;
    gain_wdata = g_new;
    step_we    = 1'b0;
    step_waddr = sidx;
    step_wdata = sbcg_pkg::UNITY_GAIN;
    if (state == sbcg_pkg::ST_CLEAR) begin
      gain_we    = ({{(32-CW){1'b0}}, clr_cnt} <= 32'(HALF_BINS));
      gain_waddr = GW'(clr_cnt);
      gain_wdata = sbcg_pkg::UNITY_GAIN;
      step_we    = ({{(32-CW){1'b0}}, clr_cnt} < 32'(LEVEL_STEPS));
      step_waddr = SW'(clr_cnt);
    end else if (accept && kind == sbcg_pkg::KIND_LOAD && ld_ok) begin
      step_we    = 1'b1;
      step_waddr = SW'(bin_index);
      step_wdata = sg_sat;
    end else if (state == sbcg_pkg::ST_SCALE) begin
      gain_we    = 1'b1;
    end
  end
  assign step_raddr = found ? sidx : SW'(LEVEL_STEPS - 1);

  // Signed 24x24 square terms and the shared unsigned 32x26 multiplier
  logic signed [47:0] sq;
  logic [31:0] mul_a;
  logic [25:0] mul_b;
  logic [57:0] mul_p;
  assign sq    = (phase == 2'd0) ? re * re : im * im;
  assign mul_p = {26'd0, mul_a} * {32'd0, mul_b};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbcg_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      phase     <= 2'd0;
    end else begin
      case (state)
        sbcg_pkg::ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if ({{(32-CW){1'b0}}, clr_cnt} == 32'(CLR - 1)) state <= sbcg_pkg::ST_IDLE;
        end
        sbcg_pkg::ST_IDLE: begin
          if (accept && kind == sbcg_pkg::KIND_BIN && bin_ok) begin
            idx   <= GW'(bin_index);
            re    <= bin_real;
            im    <= bin_imag;
            lw    <= level_weight;
            tw    <= tilt_weight;
            phase <= 2'd0;
            state <= sbcg_pkg::ST_PWR;
          end
        end
        sbcg_pkg::ST_PWR: begin
          // accumulate re^2 then im^2
          if (phase == 2'd0) begin
            pw    <= 48'(sq);
            phase <= 2'd1;
          end else begin
            pw    <= pw + 48'(sq);
            phase <= 2'd0;
            state <= sbcg_pkg::ST_TWEAK;
          end
        end
        sbcg_pkg::ST_TWEAK: begin
          // (x*w)>>16 in two halves: high word then low word
          case (phase)
            2'd0: begin
              mul_a <= {16'd0, pw[47:32]};
              mul_b <= {6'd0, lw};
              phase <= 2'd1;
            end
            2'd1: begin
              acc   <= {mul_p[44:0], 16'd0};
              mul_a <= pw[31:0];
              phase <= 2'd2;
            end
            2'd2: begin
              tp    <= acc[50:0] + {9'd0, mul_p[57:16]};
              phase <= 2'd3;
            end
            default: begin
              mul_a <= {13'd0, tp[50:32]};
              mul_b <= tw;
              sidx  <= '0;
              found <= 1'b0;
              phase <= 2'd0;
              state <= sbcg_pkg::ST_SEARCH;
            end
          endcase
        end
        sbcg_pkg::ST_SEARCH: begin
          // walk the step table; reuse the multiplier for the tilt product
          case (phase)
            2'd0: begin
              acc   <= {mul_p[44:0], 16'd0};
              mul_a <= tp[31:0];
              phase <= 2'd1;
            end
            2'd1: begin
              wp    <= acc + {19'd0, mul_p[57:16]};
              phase <= 2'd2;
            end
            default: ;
          endcase
          if (!found) begin
            if (tp < {3'd0, step_rom[sidx]}) found <= 1'b1;
            else if ({{(32-SW){1'b0}}, sidx} != 32'(LEVEL_STEPS - 1)) sidx <= sidx + 1'b1;
          end
          // leave once the tilt product is done and the floor entry is known
          if (phase == 2'd2 &&
              (found || {{(32-SW){1'b0}}, sidx} == 32'(LEVEL_STEPS - 1))) begin
            phase <= 2'd0;
            state <= sbcg_pkg::ST_GAIN;
          end
        end
        sbcg_pkg::ST_GAIN: begin
          // phase 0: step entry and bin gain reads land; phase 1: form new gain
          if (phase == 2'd0) begin
            floor_gain <= step_rd;
            phase      <= 2'd1;
          end else begin
            g_new <= reduce ? rel_g : att_g;
            phase <= 2'd0;
            state <= sbcg_pkg::ST_SCALE;
          end
        end
        sbcg_pkg::ST_SCALE: begin
          // write the new gain back and scale the bin
          pr    <= re * $signed({1'b0, invert_output ? sbcg_pkg::UNITY_GAIN - g_new : g_new});
          pi    <= im * $signed({1'b0, invert_output ? sbcg_pkg::UNITY_GAIN - g_new : g_new});
          state <= sbcg_pkg::ST_OUT;
        end
        sbcg_pkg::ST_OUT: begin
          if (!out_valid || !out_stall) state <= sbcg_pkg::ST_IDLE;
        end
        default: state <= sbcg_pkg::ST_IDLE;
      endcase
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == sbcg_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      out_index <= 10'(idx);
      out_real  <= pr[39:16];
      out_imag  <= pi[39:16];
      bin_gain  <= g_new;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
